>>> hdl/lphd_pkg.sv
// ----------------------------------------------------------------------------
// lphd_pkg
// Shared types and constants for the length-prefixed packet header decoder.
// ----------------------------------------------------------------------------
package lphd_pkg;

  // Body length that a good prefix carries, in bytes
  localparam int unsigned BODY_LEN   = 10;
  localparam int unsigned IDX_W      = 4;
  localparam logic [15:0] LEN_EXPECT = 16'(BODY_LEN);

  // Result kinds
  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_BAD_LEN = 1'b1;

  // x / 100 == (x * DIV_MUL) >> DIV_SHIFT, exact for every 16-bit x
  localparam int unsigned DIV_SHIFT = 23;
  localparam int unsigned PROD_W    = 33;
  localparam logic [16:0] DIV_MUL   = 17'd83887;

  // Queue between the byte framer and the field decoder
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // One request handed from the framer to the decoder
  typedef struct packed {
    logic        kind;
    logic [15:0] bad_len;
    logic [15:0] pid;
    logic [15:0] seq;
    logic [15:0] temp_raw;
    logic [15:0] hum_raw;
  } req_t;

endpackage

>>> hdl/lphd_front.sv
// ----------------------------------------------------------------------------
// lphd_front
// Byte framer: tracks the length prefix and the body, issues one request per
// finished frame or rejected prefix.
// ----------------------------------------------------------------------------
module lphd_front import lphd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       push,
  output req_t       req
);

  logic             in_body_r, in_body_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [7:0]       body_r [BODY_LEN];
  logic [15:0]      len_word;

  assign len_word = {rx_byte, len_lo_r};

  always_comb begin
    in_body_nxt = in_body_r;
    idx_nxt     = idx_r;
    len_lo_nxt  = len_lo_r;
    push        = 1'b0;
    req         = '0;
    req.pid      = {body_r[1], body_r[0]};
    req.seq      = {body_r[3], body_r[2]};
    req.temp_raw = {body_r[7], body_r[6]};
    req.hum_raw  = {rx_byte, body_r[8]};
    if (take) begin
      if (!in_body_r) begin
        if (idx_r == '0) begin
          len_lo_nxt = rx_byte;
          idx_nxt    = IDX_W'(1);
        end else begin
          idx_nxt = '0;
          if (len_word != LEN_EXPECT) begin
            push        = 1'b1;
            req         = '0;
            req.kind    = KIND_BAD_LEN;
            req.bad_len = len_word;
          end else begin
            in_body_nxt = 1'b1;
          end
        end
      end else if (idx_r >= IDX_W'(BODY_LEN)) begin
        // restart at the prefix
        in_body_nxt = 1'b0;
        idx_nxt     = '0;
      end else if (idx_r == IDX_W'(BODY_LEN - 1)) begin
        push        = 1'b1;
        req.kind    = KIND_PACKET;
        in_body_nxt = 1'b0;
        idx_nxt     = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r <= 1'b0;
      idx_r     <= '0;
      len_lo_r  <= '0;
    end else begin
      in_body_r <= in_body_nxt;
      idx_r     <= idx_nxt;
      len_lo_r  <= len_lo_nxt;
    end
  end

  // Body bytes need no reset: each is written before a frame reads it
  always_ff @(posedge clk) begin
    if (take && in_body_r && (idx_r < IDX_W'(BODY_LEN))) begin
      body_r[idx_r] <= rx_byte;
    end
  end

endmodule

>>> hdl/lphd_queue.sv
// ----------------------------------------------------------------------------
// lphd_queue
// Two-entry request queue between framer and decoder.
// ----------------------------------------------------------------------------
module lphd_queue import lphd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output req_t head
);

  req_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + Q_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

>>> hdl/lphd_back.sv
// ----------------------------------------------------------------------------
// lphd_back
// Field decoder: splits header words, scales sensor words by 1/100 and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module lphd_back import lphd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  req_t        q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [15:0] out_bad_length,
  output logic [2:0]  out_version,
  output logic        out_packet_kind,
  output logic        out_second_header_present,
  output logic [10:0] out_app_id,
  output logic [1:0]  out_seq_flags,
  output logic [13:0] out_sequence_count,
  output logic [9:0]  out_temperature,
  output logic [9:0]  out_humidity
);

  logic              valid_r, valid_nxt;
  logic [PROD_W-1:0] temp_prod, hum_prod;
  logic              is_pkt;

  assign pop       = q_not_empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign is_pkt    = (q_head.kind == KIND_PACKET);

  assign temp_prod = PROD_W'(q_head.temp_raw) * PROD_W'(DIV_MUL);
  assign hum_prod  = PROD_W'(q_head.hum_raw)  * PROD_W'(DIV_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load on pop; hold while stalled
  always_ff @(posedge clk) begin
    if (pop) begin
      out_result_kind           <= q_head.kind;
      out_bad_length            <= q_head.bad_len;
      out_version               <= is_pkt ? q_head.pid[15:13] : '0;
      out_packet_kind           <= is_pkt ? q_head.pid[12] : 1'b0;
      out_second_header_present <= is_pkt ? q_head.pid[11] : 1'b0;
      out_app_id                <= is_pkt ? q_head.pid[10:0] : '0;
      out_seq_flags             <= is_pkt ? q_head.seq[15:14] : '0;
      out_sequence_count        <= is_pkt ? q_head.seq[13:0] : '0;
      out_temperature           <= is_pkt ? temp_prod[DIV_SHIFT +: 10] : '0;
      out_humidity              <= is_pkt ? hum_prod[DIV_SHIFT +: 10] : '0;
    end
  end

endmodule

>>> hdl/length_prefixed_packet_header_decoder.sv
// ----------------------------------------------------------------------------
// length_prefixed_packet_header_decoder
// Decodes a little-endian length prefix and a ten-byte packet body into
// primary header fields and scaled sensor readings.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in_     | input     | in_valid / in_ready  | in_rx_byte
//  out_    | output    | out_valid / out_ready| kind, bad length, header
//          |           |                      | fields, temperature, humidity
//
//  Bytes: one byte is taken per cycle while in_ready is high. A result passes
//  through a queue slot, then the output register, before it appears on out_.
//  The request queue holds two entries; in_ready drops only while it is full,
//  so the framer stalls only when the output side has been stalled.
//  Reset: rst_n (synchronous, low) returns the framer to the length prefix
//  and empties the queue and output register.
//
module length_prefixed_packet_header_decoder import lphd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [15:0] out_bad_length,
  output logic [2:0]  out_version,
  output logic        out_packet_kind,
  output logic        out_second_header_present,
  output logic [10:0] out_app_id,
  output logic [1:0]  out_seq_flags,
  output logic [13:0] out_sequence_count,
  output logic [9:0]  out_temperature,
  output logic [9:0]  out_humidity
);

  logic take;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;
  req_t push_req;
  req_t q_head;

  // Accept a byte whenever the queue can absorb the request it might make
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Front: framing and classification of the byte stream
  lphd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .push    (push),
    .req     (push_req)
  );

  // Decouple framer and decoder
  lphd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (push_req),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // Back: field extraction, divide by 100, output register
  lphd_back u_back (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .q_not_empty               (q_not_empty),
    .q_head                    (q_head),
    .pop                       (pop),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_result_kind           (out_result_kind),
    .out_bad_length            (out_bad_length),
    .out_version               (out_version),
    .out_packet_kind           (out_packet_kind),
    .out_second_header_present (out_second_header_present),
    .out_app_id                (out_app_id),
    .out_seq_flags             (out_seq_flags),
    .out_sequence_count        (out_sequence_count),
    .out_temperature           (out_temperature),
    .out_humidity              (out_humidity)
  );

endmodule

>>> hdl/lphd_checker.sv
// ----------------------------------------------------------------------------
// lphd_checker
// Port-level checks for the packet header decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lphd_checker import lphd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_rx_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [15:0] out_bad_length,
  input logic [2:0]  out_version,
  input logic        out_packet_kind,
  input logic        out_second_header_present,
  input logic [10:0] out_app_id,
  input logic [1:0]  out_seq_flags,
  input logic [13:0] out_sequence_count,
  input logic [9:0]  out_temperature,
  input logic [9:0]  out_humidity
);

  // A stalled result stays valid and holds its kind, bad length and readings
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_bad_length) && $stable(out_temperature) && $stable(out_humidity))
    else $error("stalled result changed");

  // Decoded packets carry no rejected length
  a_pkt_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_PACKET |-> out_bad_length == '0)
    else $error("packet result with nonzero bad_length");

  // A rejected prefix is never 10 and clears every decoded field
  a_bad_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_BAD_LEN |-> out_bad_length != LEN_EXPECT
      && out_version == '0 && !out_packet_kind && !out_second_header_present
      && out_app_id == '0 && out_seq_flags == '0
      && out_sequence_count == '0 && out_temperature == '0 && out_humidity == '0)
    else $error("bad-length result malformed");

  // Scaled readings stay within 65535 / 100
  a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature <= 10'd655 && out_humidity <= 10'd655)
    else $error("scaled reading out of range");

  // Nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind length_prefixed_packet_header_decoder lphd_checker u_lphd_checker (.*);

>>> dv/tb_length_prefixed_packet_header_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_packet_header_decoder
// Self-checking bench for the length-prefixed header decoder. A short table
// covers prefix errors and field maxima. Random well-formed packets follow,
// mixed with bad prefixes and stray bytes. Both handshakes idle at random.
// Every result is compared field by field with a software decode of the
// same byte stream, or with the table header for a typed row.
// ----------------------------------------------------------------------------
module tb_length_prefixed_packet_header_decoder;
  import lphd_pkg::*;

  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS     = 22;

  // One decoded header as the output ports present it
  typedef struct packed {
    logic        kind;
    logic [15:0] bad_len;
    logic [2:0]  version;
    logic        pkt_kind;
    logic        sec_hdr;
    logic [10:0] apid;
    logic [1:0]  seq_flags;
    logic [13:0] seq_count;
    logic [9:0]  temp;
    logic [9:0]  hum;
  } hdr_result_t;

  // One directed byte; typed rows carry the header that byte completes
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    hdr_result_t want;
  } stim_row_t;

  localparam hdr_result_t NO_HDR = '0;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_result_kind;
  logic [15:0] out_bad_length;
  logic [2:0]  out_version;
  logic        out_packet_kind;
  logic        out_second_header_present;
  logic [10:0] out_app_id;
  logic [1:0]  out_seq_flags;
  logic [13:0] out_sequence_count;
  logic [9:0]  out_temperature;
  logic [9:0]  out_humidity;

  length_prefixed_packet_header_decoder i_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_rx_byte                (in_rx_byte),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_result_kind           (out_result_kind),
    .out_bad_length            (out_bad_length),
    .out_version               (out_version),
    .out_packet_kind           (out_packet_kind),
    .out_second_header_present (out_second_header_present),
    .out_app_id                (out_app_id),
    .out_seq_flags             (out_seq_flags),
    .out_sequence_count        (out_sequence_count),
    .out_temperature           (out_temperature),
    .out_humidity              (out_humidity)
  );

  // Framer state of the software decode, at its reset values
  logic             body_phase = 1'b0;
  logic [IDX_W-1:0] byte_pos   = '0;
  logic [7:0]       len_lo     = '0;
  logic [7:0]       body_buf [BODY_LEN];

  hdr_result_t pending_headers [$];
  int          mismatch_count = 0;
  int          rx_sent        = 0;
  int          cycle_count    = 0;
  bit          gapless        = 1'b0;

  // Directed table: prefix errors first (zero, all ones, off by one, bytes
  // swapped), then a good prefix and a body of all ones for the field maxima
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, NO_HDR},
    '{8'h00, 1'b1, '{KIND_BAD_LEN, 16'h0000, 3'd0, 1'b0, 1'b0, 11'd0, 2'd0, 14'd0, 10'd0, 10'd0}},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b1, '{KIND_BAD_LEN, 16'hFFFF, 3'd0, 1'b0, 1'b0, 11'd0, 2'd0, 14'd0, 10'd0, 10'd0}},
    '{8'h0B, 1'b0, NO_HDR},
    '{8'h00, 1'b1, '{KIND_BAD_LEN, 16'h000B, 3'd0, 1'b0, 1'b0, 11'd0, 2'd0, 14'd0, 10'd0, 10'd0}},
    '{8'h00, 1'b0, NO_HDR},
    '{8'h0A, 1'b1, '{KIND_BAD_LEN, 16'h0A00, 3'd0, 1'b0, 1'b0, 11'd0, 2'd0, 14'd0, 10'd0, 10'd0}},
    '{8'h09, 1'b0, NO_HDR},
    '{8'h00, 1'b1, '{KIND_BAD_LEN, 16'h0009, 3'd0, 1'b0, 1'b0, 11'd0, 2'd0, 14'd0, 10'd0, 10'd0}},
    '{8'h0A, 1'b0, NO_HDR},
    '{8'h00, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b0, NO_HDR},
    '{8'hFF, 1'b1, '{KIND_PACKET, 16'h0000, 3'd7, 1'b1, 1'b1, 11'h7FF, 2'd3, 14'h3FFF,
                     10'd655, 10'd655}}
  };

  // Free-running clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Print one line per mismatch and count it
  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got 'h%0h, expected 'h%0h", name, got, want));
  endtask

  // Idle length: mostly none, often short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Advance the software framer by one byte; flag a result when one is due
  task automatic decode_rx_byte(input logic [7:0] b, output bit produced,
                                output hdr_result_t res);
    logic [15:0] plen;
    logic [15:0] pid;
    logic [15:0] seq;
    logic [15:0] temp_w;
    logic [15:0] hum_w;
    produced = 1'b0;
    res      = NO_HDR;
    if (!body_phase) begin
      if (byte_pos == '0) begin
        len_lo   = b;
        byte_pos = IDX_W'(1);
      end else begin
        // Second prefix byte: anything but the body length is rejected
        plen     = {b, len_lo};
        byte_pos = '0;
        if (plen != LEN_EXPECT) begin
          produced    = 1'b1;
          res.kind    = KIND_BAD_LEN;
          res.bad_len = plen;
        end else begin
          body_phase = 1'b1;
        end
      end
    end else begin
      body_buf[byte_pos] = b;
      byte_pos           = byte_pos + IDX_W'(1);
      if (byte_pos == IDX_W'(BODY_LEN)) begin
        body_phase = 1'b0;
        byte_pos   = '0;
        // Little-endian words; the data length word at bytes 4..5 is unused
        pid    = {body_buf[1], body_buf[0]};
        seq    = {body_buf[3], body_buf[2]};
        temp_w = {body_buf[7], body_buf[6]};
        hum_w  = {body_buf[9], body_buf[8]};
        produced      = 1'b1;
        res.kind      = KIND_PACKET;
        res.version   = pid[15:13];
        res.pkt_kind  = pid[12];
        res.sec_hdr   = pid[11];
        res.apid      = pid[10:0];
        res.seq_flags = seq[15:14];
        res.seq_count = seq[13:0];
        res.temp      = 10'(temp_w / 16'd100);
        res.hum       = 10'(hum_w / 16'd100);
      end
    end
  endtask

  // Offer one byte after a random gap (none when gapless), hold it until taken,
  // then predict. A typed row overrides the predicted header with the table one.
  task automatic push_rx_byte(input logic [7:0] b, input bit typed,
                              input hdr_result_t want);
    int          gap;
    bit          produced;
    hdr_result_t res;
    gap = gapless ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    rx_sent++;
    decode_rx_byte(b, produced, res);
    if (typed) pending_headers.push_back(want);
    else if (produced) pending_headers.push_back(res);
  endtask

  // Result side: ready runs broken by stalls; a few long stall-free stretches
  initial begin : ready_gen
    int run;
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
      @(negedge clk) out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = idle_len();
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest pending header
  always @(posedge clk) begin : result_check
    hdr_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_headers.size() == 0) begin
        report_error("result with no header pending");
      end else begin
        want = pending_headers.pop_front();
        check_field("result_kind", 16'(out_result_kind), 16'(want.kind));
        check_field("bad_length", out_bad_length, want.bad_len);
        check_field("version", 16'(out_version), 16'(want.version));
        check_field("packet_kind", 16'(out_packet_kind), 16'(want.pkt_kind));
        check_field("second_header_present", 16'(out_second_header_present),
                    16'(want.sec_hdr));
        check_field("app_id", 16'(out_app_id), 16'(want.apid));
        check_field("seq_flags", 16'(out_seq_flags), 16'(want.seq_flags));
        check_field("sequence_count", 16'(out_sequence_count), 16'(want.seq_count));
        check_field("temperature", 16'(out_temperature), 16'(want.temp));
        check_field("humidity", 16'(out_humidity), 16'(want.hum));
      end
    end
  end

  initial begin : stimulus
    logic [15:0] word;
    logic [15:0] plen;
    int          n;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    foreach (body_buf[i]) body_buf[i] = 8'h00;

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Walk the directed table
    for (int i = 0; i < NUM_ROWS; i++)
      push_rx_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

    // Random part: mostly well-formed packets, mixed with bad prefixes and stray bytes
    while (rx_sent < NUM_ROWS + RANDOM_BYTES) begin
      gapless = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 99);
      if (n < 70) begin
        push_rx_byte(LEN_EXPECT[7:0], 1'b0, NO_HDR);
        push_rx_byte(LEN_EXPECT[15:8], 1'b0, NO_HDR);
        // Five body words; bias toward zero, all ones and division boundaries
        for (int w = 0; w < 5; w++) begin
          case ($urandom_range(0, 7))
            0:       word = 16'h0000;
            1:       word = 16'hFFFF;
            2:       word = 16'(100 * $urandom_range(0, 655));
            3:       word = 16'(100 * $urandom_range(0, 654) + 99);
            default: word = 16'($urandom);
          endcase
          push_rx_byte(word[7:0], 1'b0, NO_HDR);
          push_rx_byte(word[15:8], 1'b0, NO_HDR);
        end
      end else if (n < 90) begin
        case ($urandom_range(0, 3))
          0:       plen = 16'($urandom);
          1:       plen = 16'($urandom_range(0, 20));
          2:       plen = 16'h0A00;
          default: plen = LEN_EXPECT ^ (16'h0001 << $urandom_range(0, 15));
        endcase
        push_rx_byte(plen[7:0], 1'b0, NO_HDR);
        push_rx_byte(plen[15:8], 1'b0, NO_HDR);
      end else begin
        // Stray bytes knock the framing out of step
        repeat ($urandom_range(1, 3)) push_rx_byte(8'($urandom), 1'b0, NO_HDR);
      end
    end

    @(negedge clk) in_valid <= 1'b0;

    // Drain: wait for every pending header, then watch for extras
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/lphd_pkg.sv
hdl/lphd_front.sv
hdl/lphd_queue.sv
hdl/lphd_back.sv
hdl/length_prefixed_packet_header_decoder.sv
hdl/lphd_checker.sv
dv/tb_length_prefixed_packet_header_decoder.sv
